### rtl/jac_pkg.sv
// ----------------------------------------------------------------------------
// jac_pkg
// Shared types and constants of the joystick axis conditioner: word layouts,
// action and register codes, controller states and datapath widths.
// ----------------------------------------------------------------------------
package jac_pkg;

   // axes and sample format, fixed by the word layout
   localparam int AXES        = 2;
   localparam int SAMPLE_BITS = 12;

   // register widths
   localparam int ALPHA_W    = 9;
   localparam int DIV_W      = 12;
   localparam int LIMIT_W    = 7;
   localparam int INTERVAL_W = 8;
   localparam int CSR_DATA_W = 12;
   localparam int CSR_IDX_W  = 2;

   // datapath widths
   localparam int LEVEL_W   = SAMPLE_BITS + 8;          // Q12.8 smoothed level
   localparam int BAND_W    = SAMPLE_BITS + 2;          // signed band bound
   localparam int PROD_W    = ALPHA_W + SAMPLE_BITS;    // alpha * raw
   localparam int MTERM_W   = ALPHA_W + LEVEL_W;        // (1 - alpha) * level
   localparam int DIST_W    = BAND_W + 9;               // signed Q.8 distance
   localparam int MAG_W     = DIST_W - 1;
   localparam int NUM_W     = 2 * MAG_W - 16;           // d*d / 2^16
   localparam int DSQ_W     = 2 * DIV_W;                // divisor squared
   localparam int QUO_W     = LIMIT_W;                  // quotient below 128
   localparam int DSH_W     = DSQ_W + QUO_W;            // shifted divisor
   localparam int DIV_STEPS = QUO_W;
   localparam int MOVE_W    = 8;
   localparam int SPAN_W    = BAND_W + 1;
   localparam int WIDE_W    = BAND_W + 2;

   // span / 10 as a multiply by 2^19 / 10, rounded up
   localparam int RECIP10_W     = 16;
   localparam int RECIP10_SHIFT = 19;
   localparam logic [RECIP10_W-1:0] RECIP10 = 16'd52429;
   localparam int MARG_PROD_W   = BAND_W + RECIP10_W;
   localparam int MARGIN_W      = MARG_PROD_W - RECIP10_SHIFT;

   localparam int ALPHA_ONE = 256;

   // register reset values
   localparam logic [ALPHA_W-1:0]    ALPHA_RESET    = 9'd161;
   localparam logic [DIV_W-1:0]      DIVISOR_RESET  = 12'd200;
   localparam logic [LIMIT_W-1:0]    LIMIT_RESET    = 7'd50;
   localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd4;

   typedef enum logic [1:0] {
      ACT_CALIB  = 2'd0,
      ACT_FINISH = 2'd1,
      ACT_RUN    = 2'd2
   } action_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ALPHA    = 2'd0,
      CSR_DIVISOR  = 2'd1,
      CSR_LIMIT    = 2'd2,
      CSR_INTERVAL = 2'd3
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_MAC,
      ST_DIST,
      ST_SQUARE,
      ST_SAT,
      ST_DIV,
      ST_EMIT,
      ST_SPAN,
      ST_WIDEN
   } state_type;

   typedef struct packed {
      logic [1:0]             action;
      logic [SAMPLE_BITS-1:0] x_raw;
      logic [SAMPLE_BITS-1:0] y_raw;
   } req_type;

   typedef struct packed {
      logic signed [MOVE_W-1:0] x_move;
      logic signed [MOVE_W-1:0] y_move;
   } rsp_type;

   // effective register values as the datapath uses them
   typedef struct packed {
      logic [ALPHA_W-1:0]    alpha;
      logic [DIV_W-1:0]      divisor;
      logic [LIMIT_W-1:0]    limit;
      logic [INTERVAL_W-1:0] interval;
   } cfg_type;

   typedef struct packed {
      logic load_req;
      logic smooth_mul;
      logic smooth_mac;
      logic calib;
      logic count;
      logic distance;
      logic square;
      logic sat_chk;
      logic div_step;
      logic span;
      logic widen;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic report;
   } stat_type;

endpackage

### rtl/joystick_axis_conditioner_core.sv
// ----------------------------------------------------------------------------
// joystick_axis_conditioner_core
// Joystick axis conditioner: min/max calibration, exponential smoothing,
// dead zone, signed square curve and clamp for two axes.
//
// One word is worked on at a time and the next is taken once the sequencer
// is back in idle. A calibrate word runs the smoothing and min/max steps, a
// finish word the span and widen steps; an unused action code goes straight
// back to idle. A run word runs the smoothing steps, the dead-zone distance,
// the square, the overflow test, the restoring divider that yields one
// quotient bit per cycle and a last step that loads the output register if
// the word reports; there it waits while an earlier output word is still
// untaken. The output register lets the next word be accepted while a result
// waits. Configuration is written through csr_wr_en/csr_index/csr_wdata;
// the user must write it while the block is idle; no logic enforces this.
// ----------------------------------------------------------------------------
module joystick_axis_conditioner_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  jac_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output jac_pkg::rsp_type                 rsp_data,
   input  logic                             csr_wr_en,
   input  logic [jac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jac_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   jac_pkg::cfg_type  cfg;
   jac_pkg::cmd_type  cmd;
   jac_pkg::stat_type stat;

   // configuration registers
   jac_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // sequencer
   jac_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_action (req_data.action),
      .req_ready  (req_ready),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // axis lanes and result register
   jac_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .cfg      (cfg),
      .req_data (req_data),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

### rtl/jac_csr.sv
// ----------------------------------------------------------------------------
// jac_csr
// Configuration registers with write port; presents the values with the
// out-of-range codes mapped onto their effective settings.
// ----------------------------------------------------------------------------
module jac_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [jac_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [jac_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output jac_pkg::cfg_type                 cfg
);

   logic [jac_pkg::ALPHA_W-1:0]    alpha_ff,    alpha_in;
   logic [jac_pkg::DIV_W-1:0]      divisor_ff,  divisor_in;
   logic [jac_pkg::LIMIT_W-1:0]    limit_ff,    limit_in;
   logic [jac_pkg::INTERVAL_W-1:0] interval_ff, interval_in;

   // register write decode
   always_comb begin
      alpha_in    = alpha_ff;
      divisor_in  = divisor_ff;
      limit_in    = limit_ff;
      interval_in = interval_ff;
      if (csr_wr_en) begin
         case (jac_pkg::csr_index_type'(csr_index))
            jac_pkg::CSR_ALPHA:    alpha_in    = csr_wdata[jac_pkg::ALPHA_W-1:0];
            jac_pkg::CSR_DIVISOR:  divisor_in  = csr_wdata[jac_pkg::DIV_W-1:0];
            jac_pkg::CSR_LIMIT:    limit_in    = csr_wdata[jac_pkg::LIMIT_W-1:0];
            jac_pkg::CSR_INTERVAL: interval_in = csr_wdata[jac_pkg::INTERVAL_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         alpha_ff    <= jac_pkg::ALPHA_RESET;
         divisor_ff  <= jac_pkg::DIVISOR_RESET;
         limit_ff    <= jac_pkg::LIMIT_RESET;
         interval_ff <= jac_pkg::INTERVAL_RESET;
      end else begin
         alpha_ff    <= alpha_in;
         divisor_ff  <= divisor_in;
         limit_ff    <= limit_in;
         interval_ff <= interval_in;
      end
   end

   // alpha saturates at one, zero divisor and zero interval act as one
   always_comb begin
      cfg.alpha    = (alpha_ff > jac_pkg::ALPHA_W'(jac_pkg::ALPHA_ONE)) ?
                     jac_pkg::ALPHA_W'(jac_pkg::ALPHA_ONE) : alpha_ff;
      cfg.divisor  = (divisor_ff == '0) ? jac_pkg::DIV_W'(1) : divisor_ff;
      cfg.limit    = limit_ff;
      cfg.interval = (interval_ff == '0) ? jac_pkg::INTERVAL_W'(1) : interval_ff;
   end

endmodule

### rtl/jac_dpath.sv
// ----------------------------------------------------------------------------
// jac_dpath
// Per-axis datapath lanes: smoothing, calibration band, dead-zone distance,
// signed square and a bit-per-cycle divider, plus the result register.
// ----------------------------------------------------------------------------
module jac_dpath (
   input  logic              clock,
   input  logic              reset,
   input  jac_pkg::cmd_type  cmd,
   input  jac_pkg::cfg_type  cfg,
   input  jac_pkg::req_type  req_data,
   output jac_pkg::stat_type stat,
   output jac_pkg::rsp_type  rsp_data
);

   localparam int AXES    = jac_pkg::AXES;
   localparam int SB      = jac_pkg::SAMPLE_BITS;
   localparam int LEVEL_W = jac_pkg::LEVEL_W;
   localparam int BAND_W  = jac_pkg::BAND_W;
   localparam int WIDE_W  = jac_pkg::WIDE_W;
   localparam logic signed [BAND_W-1:0] BAND_RESET = BAND_W'(1 << SB);

   // clamp a widened bound back into the band range
   function automatic logic signed [BAND_W-1:0] band_sat(
      input logic signed [WIDE_W-1:0] v);
      logic [WIDE_W-BAND_W:0] top;
      top = v[WIDE_W-1:BAND_W-1];
      if (top == '0 || top == '1) begin
         return v[BAND_W-1:0];
      end
      return {v[WIDE_W-1], {(BAND_W-1){~v[WIDE_W-1]}}};
   endfunction

   logic [SB-1:0]                           req_raw     [AXES];
   logic [SB-1:0]                           raw_ff      [AXES];
   logic [LEVEL_W-1:0]                      level_ff    [AXES];
   logic [LEVEL_W-1:0]                      level_in    [AXES];
   logic signed [BAND_W-1:0]                low_ff      [AXES];
   logic signed [BAND_W-1:0]                low_in      [AXES];
   logic signed [BAND_W-1:0]                high_ff     [AXES];
   logic signed [BAND_W-1:0]                high_in     [AXES];
   logic [jac_pkg::PROD_W-1:0]              prod_ff     [AXES];
   logic [jac_pkg::PROD_W-1:0]              prod_in     [AXES];
   logic                                    neg_ff      [AXES];
   logic                                    neg_in      [AXES];
   logic [jac_pkg::MAG_W-1:0]               mag_ff      [AXES];
   logic [jac_pkg::MAG_W-1:0]               mag_in      [AXES];
   logic [jac_pkg::NUM_W-1:0]               rem_ff      [AXES];
   logic [jac_pkg::NUM_W-1:0]               rem_in      [AXES];
   logic                                    sat_ff      [AXES];
   logic                                    sat_in      [AXES];
   logic [jac_pkg::QUO_W-1:0]               quo_ff      [AXES];
   logic [jac_pkg::QUO_W-1:0]               quo_in      [AXES];
   logic [jac_pkg::MARG_PROD_W-1:0]         marg_ff     [AXES];
   logic [jac_pkg::MARG_PROD_W-1:0]         marg_in     [AXES];
   logic                                    span_neg_ff [AXES];
   logic                                    span_neg_in [AXES];
   logic signed [jac_pkg::MOVE_W-1:0]       move        [AXES];

   logic [jac_pkg::DSQ_W-1:0]      dsq_ff,    dsq_in;
   logic [jac_pkg::DSH_W-1:0]      dsh_ff,    dsh_in;
   logic [jac_pkg::DSH_W-1:0]      dsh_top;
   logic [jac_pkg::INTERVAL_W-1:0] cnt_ff,    cnt_in;
   logic [jac_pkg::INTERVAL_W-1:0] cnt_next;
   logic                           report_ff, report_in;
   jac_pkg::rsp_type               rsp_ff,    rsp_in;

   assign req_raw[0] = req_data.x_raw;
   assign req_raw[1] = req_data.y_raw;

   // divisor squared times 128: the first quotient step tests for overflow
   assign dsh_top = {dsq_ff, jac_pkg::QUO_W'(0)};

   // shared divisor terms and report counter
   always_comb begin
      dsq_in    = dsq_ff;
      dsh_in    = dsh_ff;
      cnt_in    = cnt_ff;
      report_in = report_ff;
      cnt_next  = cnt_ff + jac_pkg::INTERVAL_W'(1);
      if (cmd.distance) begin
         dsq_in = cfg.divisor * cfg.divisor;
      end
      if (cmd.sat_chk) begin
         dsh_in = dsh_top >> 1;
      end
      if (cmd.div_step) begin
         dsh_in = dsh_ff >> 1;
      end
      if (cmd.count) begin
         report_in = (cnt_next >= cfg.interval) || (cnt_next == '0);
         cnt_in    = report_in ? '0 : cnt_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      dsq_ff    <= dsq_in;
      dsh_ff    <= dsh_in;
      report_ff <= report_in;
   end

   for (genvar g = 0; g < AXES; g++) begin : g_lane
      logic [jac_pkg::ALPHA_W-1:0]          weight;
      logic [jac_pkg::MTERM_W-1:0]          mterm;
      logic [jac_pkg::MTERM_W-1:0]          mac_sum;
      logic signed [BAND_W-1:0]             raw_b;
      logic signed [BAND_W+7:0]             lo_q8;
      logic signed [BAND_W+7:0]             hi_q8;
      logic signed [jac_pkg::DIST_W-1:0]    s_ext;
      logic signed [jac_pkg::DIST_W-1:0]    lo_ext;
      logic signed [jac_pkg::DIST_W-1:0]    hi_ext;
      logic signed [jac_pkg::DIST_W-1:0]    dist_q8;
      logic signed [jac_pkg::DIST_W-1:0]    dist_abs;
      logic [2*jac_pkg::MAG_W-1:0]          sq;
      logic                                 ge;
      logic signed [jac_pkg::SPAN_W-1:0]    span;
      logic signed [jac_pkg::SPAN_W-1:0]    span_abs;
      logic [jac_pkg::MARGIN_W-1:0]         m_mag;
      logic signed [WIDE_W-1:0]             m_ext;
      logic signed [WIDE_W-1:0]             m_s;
      logic [jac_pkg::QUO_W-1:0]            qc;
      logic signed [jac_pkg::MOVE_W-1:0]    q_ext;

      always_comb begin
         level_in[g]    = level_ff[g];
         low_in[g]      = low_ff[g];
         high_in[g]     = high_ff[g];
         prod_in[g]     = prod_ff[g];
         neg_in[g]      = neg_ff[g];
         mag_in[g]      = mag_ff[g];
         rem_in[g]      = rem_ff[g];
         sat_in[g]      = sat_ff[g];
         quo_in[g]      = quo_ff[g];
         marg_in[g]     = marg_ff[g];
         span_neg_in[g] = span_neg_ff[g];

         // smoothing: alpha*raw, then add (1 - alpha)*old in Q.8
         weight  = jac_pkg::ALPHA_W'(jac_pkg::ALPHA_ONE) - cfg.alpha;
         mterm   = weight * level_ff[g];
         mac_sum = jac_pkg::MTERM_W'(prod_ff[g]) + (mterm >> 8);
         if (cmd.smooth_mul) begin
            prod_in[g] = cfg.alpha * raw_ff[g];
         end
         if (cmd.smooth_mac) begin
            level_in[g] = mac_sum[LEVEL_W-1:0];
         end

         // calibration tracks the raw extremes
         raw_b = BAND_W'(raw_ff[g]);
         if (cmd.calib) begin
            if (raw_b < low_ff[g]) begin
               low_in[g] = raw_b;
            end
            if (raw_b > high_ff[g]) begin
               high_in[g] = raw_b;
            end
         end

         // signed distance outside the band, low side first
         lo_q8  = {low_ff[g], 8'h00};
         hi_q8  = {high_ff[g], 8'h00};
         s_ext  = jac_pkg::DIST_W'(level_ff[g]);
         lo_ext = jac_pkg::DIST_W'(lo_q8);
         hi_ext = jac_pkg::DIST_W'(hi_q8);
         if (s_ext < lo_ext) begin
            dist_q8 = s_ext - lo_ext;
         end else if (s_ext > hi_ext) begin
            dist_q8 = s_ext - hi_ext;
         end else begin
            dist_q8 = '0;
         end
         dist_abs = dist_q8[jac_pkg::DIST_W-1] ? -dist_q8 : dist_q8;
         if (cmd.distance) begin
            neg_in[g] = dist_q8[jac_pkg::DIST_W-1];
            mag_in[g] = dist_abs[jac_pkg::MAG_W-1:0];
         end

         // square, dropping the 2^16 of the Q.8 scaling
         sq = mag_ff[g] * mag_ff[g];
         if (cmd.square) begin
            rem_in[g] = sq[2*jac_pkg::MAG_W-1:16];
         end

         // overflow test then one quotient bit per step
         if (cmd.sat_chk) begin
            sat_in[g] = jac_pkg::DSH_W'(rem_ff[g]) >= dsh_top;
            quo_in[g] = '0;
         end
         ge = jac_pkg::DSH_W'(rem_ff[g]) >= dsh_ff;
         if (cmd.div_step) begin
            if (ge) begin
               rem_in[g] = rem_ff[g] - dsh_ff[jac_pkg::NUM_W-1:0];
            end
            quo_in[g] = {quo_ff[g][jac_pkg::QUO_W-2:0], ge};
         end

         // finish: margin is a tenth of the span, toward zero
         span     = jac_pkg::SPAN_W'(high_ff[g]) - jac_pkg::SPAN_W'(low_ff[g]);
         span_abs = span[jac_pkg::SPAN_W-1] ? -span : span;
         if (cmd.span) begin
            span_neg_in[g] = span[jac_pkg::SPAN_W-1];
            marg_in[g]     = span_abs[BAND_W-1:0] * jac_pkg::RECIP10;
         end
         m_mag = marg_ff[g][jac_pkg::RECIP10_SHIFT +: jac_pkg::MARGIN_W];
         m_ext = WIDE_W'(m_mag);
         m_s   = span_neg_ff[g] ? -m_ext : m_ext;
         if (cmd.widen) begin
            low_in[g]  = band_sat(WIDE_W'(low_ff[g]) - m_s);
            high_in[g] = band_sat(WIDE_W'(high_ff[g]) + m_s);
         end

         // clamp and restore the sign
         qc       = (sat_ff[g] || quo_ff[g] > cfg.limit) ? cfg.limit : quo_ff[g];
         q_ext    = jac_pkg::MOVE_W'(qc);
         move[g]  = neg_ff[g] ? -q_ext : q_ext;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            level_ff[g] <= '0;
            low_ff[g]   <= BAND_RESET;
            high_ff[g]  <= '0;
         end else begin
            level_ff[g] <= level_in[g];
            low_ff[g]   <= low_in[g];
            high_ff[g]  <= high_in[g];
         end
      end

      always_ff @(posedge clock) begin
         if (cmd.load_req) begin
            raw_ff[g] <= req_raw[g];
         end
         prod_ff[g]     <= prod_in[g];
         neg_ff[g]      <= neg_in[g];
         mag_ff[g]      <= mag_in[g];
         rem_ff[g]      <= rem_in[g];
         sat_ff[g]      <= sat_in[g];
         quo_ff[g]      <= quo_in[g];
         marg_ff[g]     <= marg_in[g];
         span_neg_ff[g] <= span_neg_in[g];
      end
   end

   // result register
   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.x_move = move[0];
         rsp_in.y_move = move[1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_data    = rsp_ff;
   assign stat.report = report_ff;

endmodule

### rtl/jac_ctrl.sv
// ----------------------------------------------------------------------------
// jac_ctrl
// Sequencer: takes one word at a time, steps the datapath through the
// smoothing, min/max, distance, square, divide, widen steps; owns rsp_valid.
// ----------------------------------------------------------------------------
module jac_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [1:0]        req_action,
   output logic              req_ready,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  jac_pkg::stat_type stat,
   output jac_pkg::cmd_type  cmd
);

   localparam int DIV_CNT_W = $clog2(jac_pkg::DIV_STEPS);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(jac_pkg::DIV_STEPS - 1);

   jac_pkg::state_type    state_ff,   state_in;
   logic                  is_run_ff,  is_run_in;
   logic [DIV_CNT_W-1:0]  div_cnt_ff, div_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      is_run_in  = is_run_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         jac_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load_req = 1'b1;
               case (req_action)
                  jac_pkg::ACT_CALIB: begin
                     state_in  = jac_pkg::ST_MUL;
                     is_run_in = 1'b0;
                  end
                  jac_pkg::ACT_RUN: begin
                     state_in  = jac_pkg::ST_MUL;
                     is_run_in = 1'b1;
                  end
                  jac_pkg::ACT_FINISH: begin
                     state_in = jac_pkg::ST_SPAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         jac_pkg::ST_MUL: begin
            cmd.smooth_mul = 1'b1;
            cmd.calib      = !is_run_ff;
            cmd.count      = is_run_ff;
            state_in       = jac_pkg::ST_MAC;
         end
         jac_pkg::ST_MAC: begin
            cmd.smooth_mac = 1'b1;
            state_in       = is_run_ff ? jac_pkg::ST_DIST : jac_pkg::ST_IDLE;
         end
         jac_pkg::ST_DIST: begin
            cmd.distance = 1'b1;
            state_in     = jac_pkg::ST_SQUARE;
         end
         jac_pkg::ST_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = jac_pkg::ST_SAT;
         end
         jac_pkg::ST_SAT: begin
            cmd.sat_chk = 1'b1;
            div_cnt_in  = '0;
            state_in    = jac_pkg::ST_DIV;
         end
         jac_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == DIV_LAST) begin
               state_in = jac_pkg::ST_EMIT;
            end else begin
               div_cnt_in = div_cnt_ff + DIV_CNT_W'(1);
            end
         end
         jac_pkg::ST_EMIT: begin
            if (!stat.report) begin
               state_in = jac_pkg::ST_IDLE;
            end else if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = jac_pkg::ST_IDLE;
            end
         end
         jac_pkg::ST_SPAN: begin
            cmd.span = 1'b1;
            state_in = jac_pkg::ST_WIDEN;
         end
         jac_pkg::ST_WIDEN: begin
            cmd.widen = 1'b1;
            state_in  = jac_pkg::ST_IDLE;
         end
         default: begin
            state_in = jac_pkg::ST_IDLE;
         end
      endcase
   end

   // result valid: set on load, cleared when taken
   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= jac_pkg::ST_IDLE;
         is_run_ff    <= 1'b0;
         div_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         is_run_ff    <= is_run_in;
         div_cnt_ff   <= div_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // divider runs exactly its step count before the result stage
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == jac_pkg::ST_DIV && div_cnt_ff == DIV_LAST)
      |=> state_ff == jac_pkg::ST_EMIT)
      else $error("divider did not hand over to result stage");

   // unused action code leaves the sequencer idle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_action != jac_pkg::ACT_CALIB &&
       req_action != jac_pkg::ACT_FINISH && req_action != jac_pkg::ACT_RUN)
      |=> state_ff == jac_pkg::ST_IDLE)
      else $error("unused action code started work");

   // calibrate words end after smoothing, never reaching the result path
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == jac_pkg::ST_MAC && !is_run_ff)
      |=> state_ff == jac_pkg::ST_IDLE)
      else $error("calibrate word went on past smoothing");

   // a pending report waits while the output word is still held
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == jac_pkg::ST_EMIT && stat.report && rsp_valid_ff && !rsp_ready)
      |=> (state_ff == jac_pkg::ST_EMIT && rsp_valid_ff))
      else $error("report overwrote an untaken output word");

   // no output word is loaded over one that is still pending
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (state_ff == jac_pkg::ST_EMIT && (!rsp_valid_ff || rsp_ready)))
      else $error("output word loaded while slot busy");

endmodule

### tb/jac_move_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// jac_move_checker
// Watches the request, movement and register ports of the joystick axis
// conditioner, keeps its own copy of the calibration bands, smoothed levels
// and settings, works out the movement word each run word should produce and
// compares every movement word taken from the block against it.
// ----------------------------------------------------------------------------
module jac_move_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  jac_pkg::req_type               req_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  jac_pkg::rsp_type               rsp_data,
   input  logic                           csr_wr_en,
   input  logic [jac_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [jac_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             mismatch_count,
   output int                             moves_pending,
   output int                             moves_seen
);

   // mirrored block state
   logic [jac_pkg::LEVEL_W-1:0]       level_q [jac_pkg::AXES];
   logic signed [jac_pkg::BAND_W-1:0] band_lo [jac_pkg::AXES];
   logic signed [jac_pkg::BAND_W-1:0] band_hi [jac_pkg::AXES];
   logic [jac_pkg::INTERVAL_W-1:0]    run_count;

   // mirrored settings
   logic [jac_pkg::ALPHA_W-1:0]    cfg_alpha;
   logic [jac_pkg::DIV_W-1:0]      cfg_div;
   logic [jac_pkg::LIMIT_W-1:0]    cfg_limit;
   logic [jac_pkg::INTERVAL_W-1:0] cfg_interval;

   jac_pkg::rsp_type expected_moves [$];
   int               errors = 0;
   int               seen   = 0;

   // exponential average of one axis in Q12.8, weight above one taken as one
   function automatic logic [jac_pkg::LEVEL_W-1:0] smooth_level(
      logic [jac_pkg::LEVEL_W-1:0] old, logic [jac_pkg::SAMPLE_BITS-1:0] raw);
      longint unsigned a, acc, r, o;
      a   = (cfg_alpha > jac_pkg::ALPHA_ONE) ? jac_pkg::ALPHA_ONE : cfg_alpha;
      r   = raw;
      o   = old;
      acc = a * (r << 8) + (jac_pkg::ALPHA_ONE - a) * o;
      return acc[jac_pkg::LEVEL_W+7:8];
   endfunction

   // band bound kept to the signed range of its width
   function automatic logic signed [jac_pkg::BAND_W-1:0] clamp_band(longint v);
      longint hi_lim, lo_lim;
      hi_lim = (longint'(1) <<< (jac_pkg::BAND_W - 1)) - 1;
      lo_lim = -(longint'(1) <<< (jac_pkg::BAND_W - 1));
      if (v > hi_lim) return hi_lim[jac_pkg::BAND_W-1:0];
      if (v < lo_lim) return lo_lim[jac_pkg::BAND_W-1:0];
      return v[jac_pkg::BAND_W-1:0];
   endfunction

   // dead zone, signed square curve and clamp of one axis
   function automatic logic signed [jac_pkg::MOVE_W-1:0] axis_move(int ax);
      longint          s, lo, hi, d, mv;
      longint unsigned mag, dv, q;
      s  = level_q[ax];
      lo = band_lo[ax];
      hi = band_hi[ax];
      lo = lo * 256;
      hi = hi * 256;
      // inverted band: below the low bound wins over above the high bound
      if (s < lo) d = s - lo;
      else if (s > hi) d = s - hi;
      else d = 0;
      mag = (d < 0) ? -d : d;
      dv  = (cfg_div == 0) ? 1 : cfg_div;
      q   = (mag * mag) / (dv * dv * 65536);
      if (q > cfg_limit) q = cfg_limit;
      mv = (d < 0) ? -longint'(q) : longint'(q);
      return mv[jac_pkg::MOVE_W-1:0];
   endfunction

   always @(posedge clock) begin
      logic [jac_pkg::SAMPLE_BITS-1:0]   raws  [jac_pkg::AXES];
      logic signed [jac_pkg::MOVE_W-1:0] moves [jac_pkg::AXES];
      logic [jac_pkg::INTERVAL_W-1:0]    every;
      longint                            margin;
      jac_pkg::rsp_type                  want;
      if (reset) begin
         for (int ax = 0; ax < jac_pkg::AXES; ax++) begin
            level_q[ax] = '0;
            band_lo[ax] = jac_pkg::BAND_W'(1 << jac_pkg::SAMPLE_BITS);
            band_hi[ax] = '0;
         end
         run_count    = '0;
         cfg_alpha    = jac_pkg::ALPHA_RESET;
         cfg_div      = jac_pkg::DIVISOR_RESET;
         cfg_limit    = jac_pkg::LIMIT_RESET;
         cfg_interval = jac_pkg::INTERVAL_RESET;
         expected_moves.delete();
      end else begin
         // register writes
         if (csr_wr_en) begin
            case (csr_index)
               jac_pkg::CSR_ALPHA:    cfg_alpha    = csr_wdata[jac_pkg::ALPHA_W-1:0];
               jac_pkg::CSR_DIVISOR:  cfg_div      = csr_wdata[jac_pkg::DIV_W-1:0];
               jac_pkg::CSR_LIMIT:    cfg_limit    = csr_wdata[jac_pkg::LIMIT_W-1:0];
               jac_pkg::CSR_INTERVAL: cfg_interval = csr_wdata[jac_pkg::INTERVAL_W-1:0];
               default: ;
            endcase
         end

         // accepted request word
         if (req_valid && req_ready) begin
            raws[0] = req_data.x_raw;
            raws[1] = req_data.y_raw;
            case (req_data.action)
               jac_pkg::ACT_CALIB: begin
                  for (int ax = 0; ax < jac_pkg::AXES; ax++) begin
                     if ($signed({2'b00, raws[ax]}) < band_lo[ax])
                        band_lo[ax] = $signed({2'b00, raws[ax]});
                     if ($signed({2'b00, raws[ax]}) > band_hi[ax])
                        band_hi[ax] = $signed({2'b00, raws[ax]});
                     level_q[ax] = smooth_level(level_q[ax], raws[ax]);
                  end
               end
               jac_pkg::ACT_FINISH: begin
                  // widen by a tenth of the span, truncated toward zero
                  for (int ax = 0; ax < jac_pkg::AXES; ax++) begin
                     margin = (longint'(band_hi[ax]) - longint'(band_lo[ax])) / 10;
                     band_lo[ax] = clamp_band(longint'(band_lo[ax]) - margin);
                     band_hi[ax] = clamp_band(longint'(band_hi[ax]) + margin);
                  end
               end
               jac_pkg::ACT_RUN: begin
                  for (int ax = 0; ax < jac_pkg::AXES; ax++) begin
                     level_q[ax] = smooth_level(level_q[ax], raws[ax]);
                     moves[ax]   = axis_move(ax);
                  end
                  every     = (cfg_interval == 0) ? 1 : cfg_interval;
                  run_count = run_count + 1'b1;
                  if (run_count >= every || run_count == 0) begin
                     run_count   = '0;
                     want.x_move = moves[0];
                     want.y_move = moves[1];
                     expected_moves.push_back(want);
                  end
               end
               default: ;
            endcase
         end

         // movement word taken from the block
         if (rsp_valid && rsp_ready) begin
            if (expected_moves.size() == 0) begin
               errors++;
               $display("%0t: movement word x %0d y %0d with none expected, expected none",
                        $time, rsp_data.x_move, rsp_data.y_move);
            end else begin
               want = expected_moves.pop_front();
               seen++;
               if (rsp_data.x_move !== want.x_move) begin
                  errors++;
                  $display("%0t: x_move expected %0d actual %0d",
                           $time, want.x_move, rsp_data.x_move);
               end
               if (rsp_data.y_move !== want.y_move) begin
                  errors++;
                  $display("%0t: y_move expected %0d actual %0d",
                           $time, want.y_move, rsp_data.y_move);
               end
            end
         end
      end
      mismatch_count <= errors;
      moves_pending  <= expected_moves.size();
      moves_seen     <= seen;
   end

endmodule

### tb/tb_joystick_axis_conditioner_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_joystick_axis_conditioner_core
// Drives calibrate, finish, run and unused words into the conditioner under
// a series of register settings, with random gaps on the request side and
// random stalls on the movement side; the checker beside the block predicts
// and compares every movement word.
// ----------------------------------------------------------------------------
module tb_joystick_axis_conditioner_core;

   localparam logic [1:0] ACT_UNUSED = 2'd3;
   localparam int         PHASES     = 14;
   localparam int         PHASE_WORDS = 48;
   localparam int         HOLD_CYCLES = 300;
   localparam int         SETTLE_CYCLES = 24;
   localparam int         SB          = jac_pkg::SAMPLE_BITS;
   localparam int         DATA_W      = jac_pkg::CSR_DATA_W;

   logic                           clock     = 1'b0;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   jac_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   jac_pkg::rsp_type               rsp_data;
   logic                           csr_wr_en = 1'b0;
   logic [jac_pkg::CSR_IDX_W-1:0]  csr_index = '0;
   logic [DATA_W-1:0]              csr_wdata = '0;

   int mismatch_count;
   int moves_pending;
   int moves_seen;

   bit sender_gaps     = 1'b0;
   bit receiver_stalls = 1'b0;
   bit hold_request    = 1'b0;
   int hold_left       = 0;
   int stall_left      = 0;
   int words_sent      = 0;

   joystick_axis_conditioner_core u_top (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_wr_en,
      .csr_index,
      .csr_wdata
   );

   jac_move_checker u_checker (
      .clock,
      .reset,
      .req_valid,
      .req_ready,
      .req_data,
      .rsp_valid,
      .rsp_ready,
      .rsp_data,
      .csr_wr_en,
      .csr_index,
      .csr_wdata,
      .mismatch_count,
      .moves_pending,
      .moves_seen
   );

   // clock
   initial begin
      forever #6 clock = ~clock;
   end

   // run limit
   initial begin
      #(4_000_000);
      $display("Mismatches found");
      $finish;
   end

   // movement side: long hold on request, else random stall bursts
   always @(negedge clock) begin
      if (hold_request) begin
         hold_request = 1'b0;
         hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
         if (receiver_stalls && $urandom_range(0, 5) == 0)
            stall_left = $urandom_range(1, 11);
      end
   end

   // one request word, entered and left at a falling edge
   task automatic send_word(logic [1:0] action, logic [SB-1:0] x, logic [SB-1:0] y);
      jac_pkg::req_type w;
      w.action = action;
      w.x_raw  = x;
      w.y_raw  = y;
      if (sender_gaps && $urandom_range(0, 2) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      do @(posedge clock); while (!req_ready);
      words_sent++;
      @(negedge clock);
   endtask

   // stop offering words and wait until the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      do @(posedge clock); while (moves_pending != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // write all four registers, junk in the unused upper bits
   task automatic set_config(int alpha, int divisor, int limit, int interval);
      logic [DATA_W-1:0] junk;
      junk = DATA_W'($urandom);
      csr_wr_en <= 1'b1;
      csr_index <= jac_pkg::CSR_ALPHA;
      csr_wdata <= {junk[DATA_W-1:jac_pkg::ALPHA_W], jac_pkg::ALPHA_W'(alpha)};
      @(negedge clock);
      csr_index <= jac_pkg::CSR_DIVISOR;
      csr_wdata <= jac_pkg::DIV_W'(divisor);
      @(negedge clock);
      csr_index <= jac_pkg::CSR_LIMIT;
      csr_wdata <= {junk[DATA_W-1:jac_pkg::LIMIT_W], jac_pkg::LIMIT_W'(limit)};
      @(negedge clock);
      csr_index <= jac_pkg::CSR_INTERVAL;
      csr_wdata <= {junk[DATA_W-1:jac_pkg::INTERVAL_W], jac_pkg::INTERVAL_W'(interval)};
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // run sample: extremes, full range or around the centre
   function automatic logic [SB-1:0] pick_raw();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return '1;
         2, 3:    return SB'($urandom);
         default: return SB'($urandom_range(1500, 2600));
      endcase
   endfunction

   // calibration sample kept near the centre so the dead zone stays narrow
   function automatic logic [SB-1:0] centre_raw();
      return SB'($urandom_range(1950, 2150));
   endfunction

   // stimulus
   initial begin
      int left, ncal, nrun;
      int alpha, divisor, limit, interval;
      repeat (5) @(negedge clock);
      reset <= 1'b0;

      // directed: band at reset is inverted, extremes of the samples
      send_word(jac_pkg::ACT_RUN, 12'd0, 12'hFFF);
      send_word(jac_pkg::ACT_RUN, 12'hFFF, 12'd0);
      send_word(jac_pkg::ACT_RUN, 12'd0, 12'd0);
      send_word(jac_pkg::ACT_RUN, 12'hFFF, 12'hFFF);
      // unused action code is ignored
      send_word(ACT_UNUSED, 12'hABC, 12'h543);
      // finish with no calibration, then again
      send_word(jac_pkg::ACT_FINISH, 12'h555, 12'hAAA);
      send_word(jac_pkg::ACT_FINISH, 12'hAAA, 12'h555);
      send_word(jac_pkg::ACT_RUN, 12'd2048, 12'd2048);
      send_word(jac_pkg::ACT_RUN, 12'd0, 12'hFFF);
      send_word(jac_pkg::ACT_RUN, 12'hFFF, 12'd0);
      send_word(jac_pkg::ACT_RUN, 12'd1, 12'hFFE);
      // proper calibration around the centre
      send_word(jac_pkg::ACT_CALIB, 12'd2000, 12'd2100);
      send_word(jac_pkg::ACT_CALIB, 12'd2100, 12'd2000);
      send_word(jac_pkg::ACT_CALIB, 12'd2050, 12'd2050);
      send_word(jac_pkg::ACT_FINISH, 12'd0, 12'd0);
      send_word(jac_pkg::ACT_RUN, 12'd0, 12'hFFF);
      send_word(jac_pkg::ACT_RUN, 12'hFFF, 12'd0);
      send_word(jac_pkg::ACT_RUN, 12'd2050, 12'd2050);
      send_word(jac_pkg::ACT_RUN, 12'd3000, 12'd1000);

      // interval lowered below the running count
      settle();
      set_config(161, 200, 50, 1);
      send_word(jac_pkg::ACT_RUN, 12'd3500, 12'd500);
      settle();
      set_config(161, 200, 50, 8);
      repeat (5) send_word(jac_pkg::ACT_RUN, pick_raw(), pick_raw());
      settle();
      set_config(161, 200, 50, 2);
      send_word(jac_pkg::ACT_RUN, 12'd4000, 12'd100);

      // random phases under changing settings
      for (int phase = 0; phase < PHASES; phase++) begin
         settle();
         case (phase)
            0: begin
               alpha = 0; divisor = 0; limit = 0; interval = 0;
            end
            1: begin
               alpha = 256; divisor = 1; limit = 127; interval = 1;
            end
            2: begin
               alpha = 511; divisor = 4095; limit = 1; interval = 255;
            end
            default: begin
               alpha    = ($urandom_range(0, 7) == 0) ? $urandom_range(257, 511)
                                                      : $urandom_range(0, 256);
               divisor  = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 4095)
                                                      : $urandom_range(1, 300);
               limit    = $urandom_range(1, 127);
               interval = $urandom_range(1, 8);
            end
         endcase
         if (phase == 5) interval = 1;
         set_config(alpha, divisor, limit, interval);

         sender_gaps     = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
         receiver_stalls = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);

         // receiver holds off while words keep coming, so the block backs up
         if (phase == 5) begin
            @(posedge clock);
            hold_request = 1'b1;
            @(negedge clock);
         end

         left = PHASE_WORDS;
         if (phase == 11 || phase == 12) begin
            // noise: any action, any sample, repeated finishes
            while (left > 0) begin
               send_word(2'($urandom_range(0, 3)), SB'($urandom), SB'($urandom));
               left--;
            end
         end else begin
            // calibrate, finish half the time, then a stretch of run words
            ncal = $urandom_range(0, 6);
            repeat (ncal) begin
               send_word(jac_pkg::ACT_CALIB, centre_raw(), centre_raw());
               left--;
            end
            if ($urandom_range(0, 1) == 0) begin
               send_word(jac_pkg::ACT_FINISH, SB'($urandom), SB'($urandom));
               left--;
            end
            nrun = left;
            repeat (nrun) send_word(jac_pkg::ACT_RUN, pick_raw(), pick_raw());
         end
      end

      settle();
      $display("Covered %0d words over %0d setting phases, %0d movement words checked",
               words_sent, PHASES + 4, moves_seen);
      if (mismatch_count == 0 && moves_pending == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

### files.f
rtl/jac_pkg.sv
rtl/jac_csr.sv
rtl/jac_dpath.sv
rtl/jac_ctrl.sv
rtl/joystick_axis_conditioner_core.sv
tb/jac_move_checker.sv
tb/tb_joystick_axis_conditioner_core.sv
